[sv/qfw_pkg.sv]
// ----------------------------------------------------------------------------
// qfw_pkg
// Shared constants, command and status types and helper functions of the
// quad face warpage block.
// ----------------------------------------------------------------------------
package qfw_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int RES_INT        = 4;

   localparam int DIFF_TOP  = 20;
   localparam int NORM_TOP  = 30;
   localparam int DIST_FRAC = 11;

   localparam int WIDE_W  = 64;
   localparam int OP_W    = 32;
   localparam int ROOT_W  = WIDE_W / 2;
   localparam int DEN_W   = 32;
   localparam int LEAD_W  = 7;
   localparam int NRAW_W  = 2 * (DIFF_TOP + 1) + 1;
   localparam int NUM_E   = 9;
   localparam int OPIX_W  = 4;
   localparam int STEP_W  = 4;
   localparam int POS_W   = 2;
   localparam int DST_W   = 3;

   localparam logic [POS_W-1:0]  POS_LAST         = 2'd3;
   localparam logic [STEP_W-1:0] STEP_NORMAL_LAST = 4'd5;
   localparam logic [STEP_W-1:0] STEP_LAST        = 4'd14;

   // accumulator destinations
   localparam logic [DST_W-1:0] DST_NONE = 3'd0;
   localparam logic [DST_W-1:0] DST_N0   = 3'd1;
   localparam logic [DST_W-1:0] DST_N1   = 3'd2;
   localparam logic [DST_W-1:0] DST_N2   = 3'd3;
   localparam logic [DST_W-1:0] DST_NN   = 3'd4;
   localparam logic [DST_W-1:0] DST_GG   = 3'd5;
   localparam logic [DST_W-1:0] DST_DOT  = 3'd6;

   // operand codes: edge terms 0..8, normal terms 9..11
   localparam logic [OPIX_W-1:0] OP_E0 = 4'd0;
   localparam logic [OPIX_W-1:0] OP_E1 = 4'd1;
   localparam logic [OPIX_W-1:0] OP_E2 = 4'd2;
   localparam logic [OPIX_W-1:0] OP_E3 = 4'd3;
   localparam logic [OPIX_W-1:0] OP_E4 = 4'd4;
   localparam logic [OPIX_W-1:0] OP_E5 = 4'd5;
   localparam logic [OPIX_W-1:0] OP_E6 = 4'd6;
   localparam logic [OPIX_W-1:0] OP_E7 = 4'd7;
   localparam logic [OPIX_W-1:0] OP_E8 = 4'd8;
   localparam logic [OPIX_W-1:0] OP_N0 = 4'd9;
   localparam logic [OPIX_W-1:0] OP_N1 = 4'd10;
   localparam logic [OPIX_W-1:0] OP_N2 = 4'd11;

   typedef struct packed {
      logic [OPIX_W-1:0] opa;
      logic [OPIX_W-1:0] opb;
      logic              neg;
      logic              first;
      logic [DST_W-1:0]  dest;
   } step_type;

   typedef struct packed {
      logic              load_corner;
      logic [POS_W-1:0]  corner;
      logic              load_last;
      logic              diff;
      logic              lead_e;
      logic              scale_e;
      logic              mul_issue;
      logic              mul_acc;
      logic [STEP_W-1:0] step;
      logic              lead_n;
      logic              scale_n;
      logic              root_start;
      logic              div_start;
      logic              sel;
      logic              latch_nlen;
      logic              latch_glen;
      logic              latch_dist;
      logic              latch_w;
      logic              zero_w;
      logic              update_max;
      logic              emit;
   } cmd_type;

   typedef struct packed {
      logic e_zero;
      logic n_zero;
      logic len_zero;
      logic root_busy;
      logic div_busy;
   } stat_type;

   function automatic step_type step_info(input logic [STEP_W-1:0] s);
      step_type r;
      r = '{opa: OP_E0, opb: OP_E0, neg: 1'b0, first: 1'b0, dest: DST_NONE};
      case (s)
         4'd0:  r = '{opa: OP_E1, opb: OP_E5, neg: 1'b0, first: 1'b1, dest: DST_NONE};
         4'd1:  r = '{opa: OP_E2, opb: OP_E4, neg: 1'b1, first: 1'b0, dest: DST_N0};
         4'd2:  r = '{opa: OP_E2, opb: OP_E3, neg: 1'b0, first: 1'b1, dest: DST_NONE};
         4'd3:  r = '{opa: OP_E0, opb: OP_E5, neg: 1'b1, first: 1'b0, dest: DST_N1};
         4'd4:  r = '{opa: OP_E0, opb: OP_E4, neg: 1'b0, first: 1'b1, dest: DST_NONE};
         4'd5:  r = '{opa: OP_E1, opb: OP_E3, neg: 1'b1, first: 1'b0, dest: DST_N2};
         4'd6:  r = '{opa: OP_N0, opb: OP_N0, neg: 1'b0, first: 1'b1, dest: DST_NONE};
         4'd7:  r = '{opa: OP_N1, opb: OP_N1, neg: 1'b0, first: 1'b0, dest: DST_NONE};
         4'd8:  r = '{opa: OP_N2, opb: OP_N2, neg: 1'b0, first: 1'b0, dest: DST_NN};
         4'd9:  r = '{opa: OP_E3, opb: OP_E3, neg: 1'b0, first: 1'b1, dest: DST_NONE};
         4'd10: r = '{opa: OP_E4, opb: OP_E4, neg: 1'b0, first: 1'b0, dest: DST_NONE};
         4'd11: r = '{opa: OP_E5, opb: OP_E5, neg: 1'b0, first: 1'b0, dest: DST_GG};
         4'd12: r = '{opa: OP_E6, opb: OP_N0, neg: 1'b0, first: 1'b1, dest: DST_NONE};
         4'd13: r = '{opa: OP_E7, opb: OP_N1, neg: 1'b0, first: 1'b0, dest: DST_NONE};
         4'd14: r = '{opa: OP_E8, opb: OP_N2, neg: 1'b0, first: 1'b0, dest: DST_DOT};
         default: r = '{opa: OP_E0, opb: OP_E0, neg: 1'b0, first: 1'b1, dest: DST_NONE};
      endcase
      return r;
   endfunction

   function automatic logic [WIDE_W-1:0] mag64(input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-1:0] r;
      r = v[WIDE_W-1] ? WIDE_W'(-v) : WIDE_W'(v);
      return r;
   endfunction

   function automatic logic [LEAD_W-1:0] lead_pos(input logic [WIDE_W-1:0] v);
      logic [LEAD_W-1:0] p;
      p = '0;
      for (int i = 0; i < WIDE_W; i++) begin
         if (v[i]) begin
            p = LEAD_W'(i);
         end
      end
      return p;
   endfunction

   // power-of-two scaling, right shifts truncate toward zero
   function automatic logic signed [WIDE_W-1:0] scale_pow2(
      input logic signed [WIDE_W-1:0] v,
      input logic [LEAD_W-1:0]        p,
      input logic [LEAD_W-1:0]        top
   );
      logic [LEAD_W-1:0]        s;
      logic [WIDE_W-1:0]        m;
      logic signed [WIDE_W-1:0] r;
      m = mag64(v);
      if (p > top - 1'b1) begin
         s = p - (top - 1'b1);
         m = m >> s;
         r = v[WIDE_W-1] ? -$signed(m) : $signed(m);
      end else begin
         s = (top - 1'b1) - p;
         r = v <<< s;
      end
      return r;
   endfunction

endpackage

[sv/qfw_isqrt.sv]
// ----------------------------------------------------------------------------
// qfw_isqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module qfw_isqrt #(
   parameter int IN_W = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [IN_W-1:0]     radicand,
   output logic                busy,
   output logic [IN_W/2-1:0]   root
);
   localparam int RW    = IN_W / 2;
   localparam int REM_W = RW + 2;
   localparam int CNT_W = $clog2(RW + 1);

   logic [IN_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   logic [REM_W+1:0] rem_sh, trial;

   always_comb begin
      rem_sh  = {rem_ff, rad_ff[IN_W-1 -: 2]};
      trial   = (REM_W + 2)'({root_ff, 2'b01});
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(RW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[IN_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = REM_W'(rem_sh - trial);
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_sh);
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

[sv/qfw_div.sv]
// ----------------------------------------------------------------------------
// qfw_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qfw_div #(
   parameter int NUM_W = 64,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;

   logic [DEN_W:0] rem_sh;
   logic           ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NUM_W-2:0], ge};
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : DEN_W'(rem_sh);
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign quot = num_ff;

endmodule

[sv/qfw_ctrl.sv]
// ----------------------------------------------------------------------------
// qfw_ctrl
// Sequencer of the quad face warpage block: corner position, face
// evaluation steps and the result word register's valid.
// ----------------------------------------------------------------------------
module qfw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_cell_end,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  qfw_pkg::stat_type stat,
   output qfw_pkg::cmd_type  cmd
);
   import qfw_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DIFF     = 4'd1;
   localparam logic [3:0] S_LEADE    = 4'd2;
   localparam logic [3:0] S_SCALEE   = 4'd3;
   localparam logic [3:0] S_MULA     = 4'd4;
   localparam logic [3:0] S_MULB     = 4'd5;
   localparam logic [3:0] S_LEADN    = 4'd6;
   localparam logic [3:0] S_SCALEN   = 4'd7;
   localparam logic [3:0] S_ROOTGO   = 4'd8;
   localparam logic [3:0] S_ROOTWAIT = 4'd9;
   localparam logic [3:0] S_LENCHK   = 4'd10;
   localparam logic [3:0] S_DIVGO    = 4'd11;
   localparam logic [3:0] S_DIVWAIT  = 4'd12;
   localparam logic [3:0] S_UPDATE   = 4'd13;
   localparam logic [3:0] S_FINISH   = 4'd14;
   localparam logic [3:0] S_EMIT     = 4'd15;

   logic [3:0]        state_ff, state_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              end_ff, end_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              pass_ff, pass_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic stall_c, accept, take;

   always_comb begin
      stall_c      = (state_ff != S_IDLE) || (req_cell_end && rsp_valid_ff && rsp_stall);
      accept       = req_valid && !stall_c;
      take         = rsp_valid_ff && !rsp_stall;
      state_in     = state_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && !take;
      cmd          = '0;
      cmd.corner   = pos_ff;
      cmd.step     = step_ff;
      cmd.sel      = pass_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (pos_ff != POS_LAST) begin
                  cmd.load_corner = 1'b1;
                  pos_in = req_cell_end ? '0 : pos_ff + 1'b1;
                  if (req_cell_end) begin
                     cmd.emit     = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  cmd.load_last = 1'b1;
                  pos_in   = '0;
                  end_in   = req_cell_end;
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            step_in  = '0;
            pass_in  = 1'b0;
            state_in = S_LEADE;
         end
         S_LEADE: begin
            cmd.lead_e = 1'b1;
            state_in   = S_SCALEE;
         end
         S_SCALEE: begin
            if (stat.e_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.scale_e = 1'b1;
               state_in    = S_MULA;
            end
         end
         S_MULA: begin
            cmd.mul_issue = 1'b1;
            state_in      = S_MULB;
         end
         S_MULB: begin
            cmd.mul_acc = 1'b1;
            step_in     = step_ff + 1'b1;
            if (step_ff == STEP_NORMAL_LAST) begin
               state_in = S_LEADN;
            end else if (step_ff == STEP_LAST) begin
               state_in = S_ROOTGO;
            end else begin
               state_in = S_MULA;
            end
         end
         S_LEADN: begin
            cmd.lead_n = 1'b1;
            state_in   = S_SCALEN;
         end
         S_SCALEN: begin
            if (stat.n_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.scale_n = 1'b1;
               state_in    = S_MULA;
            end
         end
         S_ROOTGO: begin
            cmd.root_start = 1'b1;
            state_in       = S_ROOTWAIT;
         end
         S_ROOTWAIT: begin
            if (!stat.root_busy) begin
               if (!pass_ff) begin
                  cmd.latch_nlen = 1'b1;
                  pass_in  = 1'b1;
                  state_in = S_ROOTGO;
               end else begin
                  cmd.latch_glen = 1'b1;
                  pass_in  = 1'b0;
                  state_in = S_LENCHK;
               end
            end
         end
         S_LENCHK: begin
            if (stat.len_zero) begin
               cmd.zero_w = 1'b1;
               state_in   = S_UPDATE;
            end else begin
               state_in = S_DIVGO;
            end
         end
         S_DIVGO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIVWAIT;
         end
         S_DIVWAIT: begin
            if (!stat.div_busy) begin
               if (!pass_ff) begin
                  cmd.latch_dist = 1'b1;
                  pass_in  = 1'b1;
                  state_in = S_DIVGO;
               end else begin
                  cmd.latch_w = 1'b1;
                  pass_in  = 1'b0;
                  state_in = S_UPDATE;
               end
            end
         end
         S_UPDATE: begin
            cmd.update_max = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            state_in = end_ff ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               end_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         end_ff       <= 1'b0;
         step_ff      <= '0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         end_ff       <= end_in;
         step_ff      <= step_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = stall_c;
   assign rsp_valid = rsp_valid_ff;

endmodule

[sv/qfw_datapath.sv]
// ----------------------------------------------------------------------------
// qfw_datapath
// Corner registers, edge and normal scaling, shared multiply-accumulate,
// root and divide units, running maximum and result word register.
// ----------------------------------------------------------------------------
module qfw_datapath #(
   parameter int COORD_BITS = qfw_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = qfw_pkg::FRAC_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic signed [COORD_BITS-1:0]               req_coord_x,
   input  logic signed [COORD_BITS-1:0]               req_coord_y,
   input  logic signed [COORD_BITS-1:0]               req_coord_z,
   input  qfw_pkg::cmd_type                           cmd,
   output qfw_pkg::stat_type                          stat,
   output logic [qfw_pkg::RES_INT+FRAC_BITS-1:0]      rsp_cell_warpage
);
   import qfw_pkg::*;

   localparam int DIFF_W = COORD_BITS + 1;
   localparam int RES_W  = RES_INT + FRAC_BITS;

   logic signed [COORD_BITS-1:0] c_ff [3][3];
   logic signed [COORD_BITS-1:0] p_ff [3];
   logic signed [COORD_BITS-1:0] coord [3];

   logic signed [DIFF_W-1:0]   e_raw_ff [NUM_E];
   logic signed [DIFF_W-1:0]   e_raw_in [NUM_E];
   logic signed [DIFF_TOP:0]   e_ff [NUM_E];
   logic signed [WIDE_W-1:0]   e_scaled [NUM_E];
   logic signed [NRAW_W-1:0]   n_raw_ff [3];
   logic signed [NORM_TOP:0]   n_ff [3];
   logic signed [WIDE_W-1:0]   n_scaled [3];

   logic [LEAD_W-1:0] lead_ff;
   logic              e_zero_ff, n_zero_ff;
   logic [WIDE_W-1:0] or_e, or_n;

   step_type                 info;
   logic signed [OP_W-1:0]   op_a, op_b;
   logic signed [WIDE_W-1:0] prod_ff, prod_in, acc_ff, acc_in;

   logic [WIDE_W-1:0]        nn_ff, gg_ff;
   logic signed [WIDE_W-1:0] dot_ff;
   logic [ROOT_W-1:0]        nlen_ff, glen_ff, root_q;
   logic [WIDE_W-1:0]        dist_ff, quot, div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     root_busy, div_busy;

   logic [RES_W-1:0] face_w_ff, max_ff, rsp_w_ff, w_sat;

   assign coord[0] = req_coord_x;
   assign coord[1] = req_coord_y;
   assign coord[2] = req_coord_z;

   function automatic logic signed [OP_W-1:0] pick(
      input logic [OPIX_W-1:0]    ix,
      input logic signed [DIFF_TOP:0] e0, e1, e2, e3, e4, e5, e6, e7, e8,
      input logic signed [NORM_TOP:0] n0, n1, n2
   );
      logic signed [OP_W-1:0] r;
      case (ix)
         OP_E0:   r = OP_W'(e0);
         OP_E1:   r = OP_W'(e1);
         OP_E2:   r = OP_W'(e2);
         OP_E3:   r = OP_W'(e3);
         OP_E4:   r = OP_W'(e4);
         OP_E5:   r = OP_W'(e5);
         OP_E6:   r = OP_W'(e6);
         OP_E7:   r = OP_W'(e7);
         OP_E8:   r = OP_W'(e8);
         OP_N0:   r = OP_W'(n0);
         OP_N1:   r = OP_W'(n1);
         OP_N2:   r = OP_W'(n2);
         default: r = '0;
      endcase
      return r;
   endfunction

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         e_raw_in[a]     = DIFF_W'(c_ff[1][a]) - DIFF_W'(c_ff[0][a]);
         e_raw_in[3 + a] = DIFF_W'(c_ff[2][a]) - DIFF_W'(c_ff[0][a]);
         e_raw_in[6 + a] = DIFF_W'(p_ff[a])    - DIFF_W'(c_ff[0][a]);
      end
      or_e = '0;
      for (int i = 0; i < NUM_E; i++) begin
         or_e        = or_e | mag64(WIDE_W'(e_raw_ff[i]));
         e_scaled[i] = scale_pow2(WIDE_W'(e_raw_ff[i]), lead_ff, LEAD_W'(DIFF_TOP));
      end
      or_n = '0;
      for (int i = 0; i < 3; i++) begin
         or_n        = or_n | mag64(WIDE_W'(n_raw_ff[i]));
         n_scaled[i] = scale_pow2(WIDE_W'(n_raw_ff[i]), lead_ff, LEAD_W'(NORM_TOP));
      end
   end

   // shared multiplier and accumulator
   always_comb begin
      info = step_info(cmd.step);
      op_a = pick(info.opa, e_ff[0], e_ff[1], e_ff[2], e_ff[3], e_ff[4], e_ff[5],
                  e_ff[6], e_ff[7], e_ff[8], n_ff[0], n_ff[1], n_ff[2]);
      op_b = pick(info.opb, e_ff[0], e_ff[1], e_ff[2], e_ff[3], e_ff[4], e_ff[5],
                  e_ff[6], e_ff[7], e_ff[8], n_ff[0], n_ff[1], n_ff[2]);
      prod_in = op_a * op_b;
      acc_in  = (info.first ? '0 : acc_ff) + (info.neg ? -prod_ff : prod_ff);
   end

   always_comb begin
      if (!cmd.sel) begin
         div_num = mag64(dot_ff) << DIST_FRAC;
         div_den = DEN_W'(nlen_ff);
      end else begin
         div_num = dist_ff << FRAC_BITS;
         div_den = {glen_ff[DEN_W-1-DIST_FRAC:0], {DIST_FRAC{1'b0}}};
      end
      w_sat = (|quot[WIDE_W-1:RES_W]) ? '1 : quot[RES_W-1:0];
   end

   qfw_isqrt #(
      .IN_W (WIDE_W)
   ) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (cmd.sel ? gg_ff : nn_ff),
      .busy     (root_busy),
      .root     (root_q)
   );

   qfw_div #(
      .NUM_W (WIDE_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .numer (div_num),
      .denom (div_den),
      .busy  (div_busy),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_corner) begin
         for (int a = 0; a < 3; a++) begin
            c_ff[cmd.corner][a] <= coord[a];
         end
      end
      if (cmd.load_last) begin
         for (int a = 0; a < 3; a++) begin
            p_ff[a] <= coord[a];
         end
      end
      if (cmd.diff) begin
         for (int i = 0; i < NUM_E; i++) begin
            e_raw_ff[i] <= e_raw_in[i];
         end
      end
      if (cmd.lead_e) begin
         lead_ff   <= lead_pos(or_e);
         e_zero_ff <= (or_e == '0);
      end
      if (cmd.lead_n) begin
         lead_ff   <= lead_pos(or_n);
         n_zero_ff <= (or_n == '0);
      end
      if (cmd.scale_e) begin
         for (int i = 0; i < NUM_E; i++) begin
            e_ff[i] <= e_scaled[i][DIFF_TOP:0];
         end
      end
      if (cmd.scale_n) begin
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= n_scaled[i][NORM_TOP:0];
         end
      end
      if (cmd.mul_issue) begin
         prod_ff <= prod_in;
      end
      if (cmd.mul_acc) begin
         acc_ff <= acc_in;
         case (info.dest)
            DST_N0:   n_raw_ff[0] <= acc_in[NRAW_W-1:0];
            DST_N1:   n_raw_ff[1] <= acc_in[NRAW_W-1:0];
            DST_N2:   n_raw_ff[2] <= acc_in[NRAW_W-1:0];
            DST_NN:   nn_ff       <= acc_in;
            DST_GG:   gg_ff       <= acc_in;
            DST_DOT:  dot_ff      <= acc_in;
            default:  ;
         endcase
      end
      if (cmd.latch_nlen) begin
         nlen_ff <= root_q;
      end
      if (cmd.latch_glen) begin
         glen_ff <= root_q;
      end
      if (cmd.latch_dist) begin
         dist_ff <= quot;
      end
      if (cmd.latch_w) begin
         face_w_ff <= w_sat;
      end else if (cmd.zero_w) begin
         face_w_ff <= '0;
      end
      if (cmd.emit) begin
         rsp_w_ff <= max_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else if (cmd.emit) begin
         max_ff <= '0;
      end else if (cmd.update_max && (face_w_ff > max_ff)) begin
         max_ff <= face_w_ff;
      end
   end

   assign stat.e_zero    = e_zero_ff;
   assign stat.n_zero    = n_zero_ff;
   assign stat.len_zero  = (nlen_ff == '0) || (glen_ff == '0);
   assign stat.root_busy = root_busy;
   assign stat.div_busy  = div_busy;

   assign rsp_cell_warpage = rsp_w_ff;

endmodule

[sv/quad_face_warpage.sv]
// ----------------------------------------------------------------------------
// quad_face_warpage
// Largest quadrilateral face warpage of a hexahedral cell, fed one vertex
// word at a time, four corners per face.
//
// req channel: one vertex word (x, y, z in signed fixed point, cell_end).
// rsp channel: one word per cell_end, the largest face warpage, unsigned
//   Q4.16 fixed point (Q4.FRAC_BITS), saturating.
// Corners 0..2 of a face are stored in the corner registers. Corner 3 starts
// the face evaluation: 6 cross-product and 9 dot-product multiply-accumulate
// steps, two square roots of 32 root bits and two divisions of 64 quotient
// bits, cut short when the edges or the normal are all zero or a length is
// zero; req_stall is high while the evaluation runs.
// The result word sits in an output register; vertex words keep flowing
// while it waits, and only a word with cell_end stalls while the result
// register is still full and stalled.
// A cell_end on corner 3 gives its result right after that face.
// Reset empties the result register, the corner position and the running
// maximum; there is no start-up pass.
// ----------------------------------------------------------------------------
module quad_face_warpage #(
   parameter int COORD_BITS = qfw_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = qfw_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_coord_x,
   input  logic signed [COORD_BITS-1:0]          req_coord_y,
   input  logic signed [COORD_BITS-1:0]          req_coord_z,
   input  logic                                  req_cell_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [qfw_pkg::RES_INT+FRAC_BITS-1:0] rsp_cell_warpage
);
   import qfw_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   qfw_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_cell_end (req_cell_end),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .stat         (stat),
      .cmd          (cmd)
   );

   qfw_datapath #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_cell_warpage (rsp_cell_warpage)
   );

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(stat.root_busy && stat.div_busy))
      else $error("root and divide units busy together");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid)
      else $error("result word not presented after emit");

   a_root_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.root_start |=> stat.root_busy)
      else $error("root unit did not start");

endmodule
